// File: design/uev_pkg.sv
// ----------------------------------------------------------------------------
// uev_pkg: shared types for the unicode escape validator
// Status codes, parse phases, the per-escape state and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

package uev_pkg;

    localparam int unsigned CpW = 21;
    localparam int unsigned CountW = 3;

    localparam logic [CpW-1:0] MaxCode  = 21'h10FFFF;
    localparam logic [CpW-1:0] SurrLo   = 21'h00D800;
    localparam logic [CpW-1:0] SurrHi   = 21'h00DFFF;
    localparam logic [7:0]     ChPrefix = 8'h75;
    localparam logic [7:0]     ChSep    = 8'h5F;
    localparam logic [7:0]     ChNul    = 8'h00;
    localparam logic [CountW-1:0] CountMax = 3'd7;
    localparam logic [CountW-1:0] MinDigits = 3'd4;

    typedef enum logic [3:0] {
        ST_PENDING   = 4'd0,
        ST_VALID     = 4'd1,
        ST_NO_U      = 4'd2,
        ST_NON_HEX   = 4'd3,
        ST_LOWER     = 4'd4,
        ST_RANGE     = 4'd5,
        ST_SURROGATE = 4'd6,
        ST_SHORT     = 4'd7,
        ST_LEAD_ZERO = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_START  = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [CpW-1:0]      value;
        logic [CountW-1:0]   digit_count;
        logic                lead_zero;
        status_t             verdict;
    } esc_state_t;

    typedef struct packed {
        status_t         status;
        logic [CpW-1:0]  code_point;
        logic            point_ready;
    } esc_result_t;

    localparam esc_state_t StateClear = '{
        phase:       PH_PREFIX,
        value:       '0,
        digit_count: '0,
        lead_zero:   1'b0,
        verdict:     ST_PENDING
    };

endpackage

`default_nettype wire

// File: design/unicode_escape_validator.sv
// ----------------------------------------------------------------------------
// unicode_escape_validator: streaming checker for u-prefixed code-point escapes
// Result word is registered, valid the cycle after accept; throughput 1 word/cycle
// while the sink keeps up, as uev_step updates state combinationally. Reset (aresetn
// low, sync) clears the parse state to "expect u" and empties the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module unicode_escape_validator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream: one character per word
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic [0:0]  s_tuser,   // [0] first
    // result stream: one result per character
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [3:0] status, [24:4] code_point, [31:25] zero
    output logic [0:0]       m_tuser    // [0] point_ready
);

    // Parse state lives here; the whole per-character update is a short
    // cone in uev_step between this register and the result register.
    uev_pkg::esc_state_t  state_reg;
    uev_pkg::esc_state_t  state_next;
    uev_pkg::esc_result_t step_result;

    // Result register: one word deep. It is refilled in the same cycle it
    // is drained, so a character enters every cycle the sink keeps up.
    logic                 out_valid_reg;
    uev_pkg::esc_result_t out_reg;
    logic                 s_accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    uev_step u_step (
        .ch         (s_tdata),
        .first      (s_tuser[0]),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    // control state: parse state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= uev_pkg::StateClear;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg <= state_next;
            end
            if (s_accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.code_point, out_reg.status};
    assign m_tuser  = out_reg.point_ready;

`ifndef ASSERT_OFF
    // a finished code point only ever comes with a pending or valid status
    a_ready_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata[3:0] == uev_pkg::ST_PENDING || m_tdata[3:0] == uev_pkg::ST_VALID))
        else $error("point_ready with a failing status");

    // the verdict is set exactly when parsing is done
    a_verdict_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.verdict != uev_pkg::ST_PENDING) == (state_reg.phase == uev_pkg::PH_DONE))
        else $error("verdict and phase disagree");

    // running value never leaves the code space
    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.value <= uev_pkg::MaxCode)
        else $error("running value above 0x10FFFF");

    // waiting for a component's first digit means a cleared accumulator
    a_start_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == uev_pkg::PH_START) |->
            (state_reg.value == '0 && state_reg.digit_count == '0))
        else $error("component start with stale value");

    // a stalled result word is not overwritten
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result word changed while stalled");
`endif

endmodule

`default_nettype wire

// File: design/uev_step.sv
// ----------------------------------------------------------------------------
// uev_step: one-character update of the escape parser
// Pure combinational: current state plus one character gives next state
// and the result word for that character.
// ----------------------------------------------------------------------------
`default_nettype none

module uev_step (
    input  wire logic [7:0]         ch,
    input  wire logic               first,
    input  wire uev_pkg::esc_state_t state_cur,
    output uev_pkg::esc_state_t     state_next,
    output uev_pkg::esc_result_t    result
);

    uev_pkg::esc_state_t st;
    logic                is_dec;
    logic                is_upper;
    logic                is_lower;
    logic [3:0]          digit;
    logic [uev_pkg::CpW+3:0] nv;
    logic                is_end;
    logic                is_surr;
    logic [uev_pkg::CpW-1:0] cp;
    logic                ready;

    always_comb begin
        is_dec   = (ch >= 8'h30) && (ch <= 8'h39);
        is_upper = (ch >= 8'h41) && (ch <= 8'h46);
        is_lower = (ch >= 8'h61) && (ch <= 8'h66);
        // 'A'..'F' carry 1..6 in the low nibble
        digit    = is_dec ? ch[3:0] : (ch[3:0] + 4'd9);
        is_end   = (ch == uev_pkg::ChNul) || (ch == uev_pkg::ChSep);
    end

    always_comb begin
        st         = first ? uev_pkg::StateClear : state_cur;
        state_next = st;
        cp         = st.value;
        ready      = 1'b0;
        // value is at most 0x10FFFF, so shifting in a digit fits in 25 bits
        nv         = {st.value, digit};
        is_surr    = (st.value >= uev_pkg::SurrLo) && (st.value <= uev_pkg::SurrHi);

        case (st.phase)
            uev_pkg::PH_PREFIX: begin
                if (ch == uev_pkg::ChPrefix) begin
                    state_next       = uev_pkg::StateClear;
                    state_next.phase = uev_pkg::PH_START;
                end else begin
                    state_next.verdict = uev_pkg::ST_NO_U;
                    state_next.phase   = uev_pkg::PH_DONE;
                end
            end
            uev_pkg::PH_START, uev_pkg::PH_DIGITS: begin
                if (st.phase == uev_pkg::PH_DIGITS && is_end) begin
                    if (is_surr) begin
                        state_next.verdict = uev_pkg::ST_SURROGATE;
                        state_next.phase   = uev_pkg::PH_DONE;
                    end else if (st.digit_count < uev_pkg::MinDigits) begin
                        state_next.verdict = uev_pkg::ST_SHORT;
                        state_next.phase   = uev_pkg::PH_DONE;
                    end else if (st.digit_count > uev_pkg::MinDigits && st.lead_zero) begin
                        state_next.verdict = uev_pkg::ST_LEAD_ZERO;
                        state_next.phase   = uev_pkg::PH_DONE;
                    end else begin
                        ready = 1'b1;
                        if (ch == uev_pkg::ChNul) begin
                            state_next.verdict = uev_pkg::ST_VALID;
                            state_next.phase   = uev_pkg::PH_DONE;
                        end else begin
                            state_next       = uev_pkg::StateClear;
                            state_next.phase = uev_pkg::PH_START;
                        end
                    end
                end else if (!(is_dec || is_upper)) begin
                    state_next.verdict = is_lower ? uev_pkg::ST_LOWER
                                                  : uev_pkg::ST_NON_HEX;
                    state_next.phase   = uev_pkg::PH_DONE;
                end else if (nv > {4'd0, uev_pkg::MaxCode}) begin
                    state_next.verdict = uev_pkg::ST_RANGE;
                    state_next.phase   = uev_pkg::PH_DONE;
                end else begin
                    if (st.phase == uev_pkg::PH_START) begin
                        state_next.lead_zero = (digit == 4'd0);
                    end
                    state_next.value = nv[uev_pkg::CpW-1:0];
                    if (st.digit_count < uev_pkg::CountMax) begin
                        state_next.digit_count = st.digit_count + 3'd1;
                    end
                    state_next.phase = uev_pkg::PH_DIGITS;
                    cp               = nv[uev_pkg::CpW-1:0];
                end
            end
            default: begin
                // verdict reached: hold until the next escape starts
                state_next = st;
            end
        endcase

        result.status      = state_next.verdict;
        result.code_point  = cp;
        result.point_ready = ready;
    end

endmodule

`default_nettype wire

// File: tb/sv/unicode_escape_validator_tb.sv
// ----------------------------------------------------------------------------
// unicode_escape_validator_tb: self-checking bench for the escape validator
// Streams characters into the block and models each one in a local copy of the
// parse state. Every result word is compared field by field against that model.
// A short directed list comes first. Random escapes follow, mostly well formed,
// with flaws injected per component. Both sides idle at random, and there is one
// long result hold-off that backs the block up.
// ----------------------------------------------------------------------------

module unicode_escape_validator_tb;

    localparam int TargetWords   = 1100;  // counted characters of live escapes
    localparam int BacklogAt     = 400;   // result count that starts the long hold
    localparam int BacklogHold   = 300;   // cycles of m_tready low for that hold
    localparam int WatchdogLimit = 2000;  // cycles with no handshake on either side
    localparam int DrainCycles   = 4;     // tail after the last expected word
    localparam int unsigned Radix = 16;

    localparam logic [7:0] ChDigit0 = "0";
    localparam logic [7:0] ChDigit9 = "9";
    localparam logic [7:0] ChUpperA = "A";
    localparam logic [7:0] ChUpperF = "F";
    localparam logic [7:0] ChLowerA = "a";
    localparam logic [7:0] ChLowerF = "f";

    // kinds of damage the random part puts into one component
    typedef enum int {
        FL_NONE,
        FL_SHORT,     // 0..3 digits, zero digits gives an empty component
        FL_PADDED,    // 5..9 digits with a leading '0'
        FL_SURR,      // value inside the surrogate block
        FL_OVER,      // value above the top code point
        FL_LOWER,     // one digit written in lowercase
        FL_BADCHAR    // one digit replaced by a non-hex byte
    } flaw_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
    } char_word_t;

    // ------------------------------------------------------------------------
    // clock, reset, DUT
    // ------------------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // [7:0] ch
    logic [0:0]  s_tuser = '0;     // [0] first
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [3:0] status, [24:4] code_point, [31:25] zero
    logic [0:0]  m_tuser;          // [0] point_ready

    initial begin
        forever #2 aclk = ~aclk;
    end

    unicode_escape_validator u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------------
    // escape model: local parse state and one-character step
    // ------------------------------------------------------------------------
    uev_pkg::esc_state_t  escape_state = uev_pkg::StateClear;
    uev_pkg::esc_result_t escape_results_due[$];   // predicted result words, oldest first

    function automatic uev_pkg::esc_result_t step_escape(input logic [7:0] ch,
                                                         input logic       first);
        uev_pkg::esc_result_t    res;
        logic [uev_pkg::CpW-1:0] shown;
        logic                    ready;
        logic [3:0]              digit;
        logic                    is_digit;
        logic                    is_end;
        int unsigned             grown;

        if (first)
            escape_state = uev_pkg::StateClear;
        shown = escape_state.value;
        ready = 1'b0;
        is_end = (ch == uev_pkg::ChNul) || (ch == uev_pkg::ChSep);

        // decode the character once; only the digit phases look at it
        is_digit = 1'b1;
        if (ch >= ChDigit0 && ch <= ChDigit9)
            digit = 4'(ch - ChDigit0);
        else if (ch >= ChUpperA && ch <= ChUpperF)
            digit = 4'(ch - ChUpperA + 8'd10);
        else begin
            is_digit = 1'b0;
            digit = '0;
        end

        case (escape_state.phase)
            uev_pkg::PH_PREFIX: begin
                if (ch == uev_pkg::ChPrefix) begin
                    escape_state.phase = uev_pkg::PH_START;
                    escape_state.value = '0;
                    escape_state.digit_count = '0;
                    escape_state.lead_zero = 1'b0;
                end else begin
                    // anything else, NUL too, means the prefix is missing
                    escape_state.verdict = uev_pkg::ST_NO_U;
                    escape_state.phase = uev_pkg::PH_DONE;
                end
            end
            uev_pkg::PH_START, uev_pkg::PH_DIGITS: begin
                if (escape_state.phase == uev_pkg::PH_DIGITS && is_end) begin
                    // component closes: surrogate, then length, then leading zero
                    if (escape_state.value >= uev_pkg::SurrLo &&
                        escape_state.value <= uev_pkg::SurrHi)
                        escape_state.verdict = uev_pkg::ST_SURROGATE;
                    else if (escape_state.digit_count < uev_pkg::MinDigits)
                        escape_state.verdict = uev_pkg::ST_SHORT;
                    else if (escape_state.digit_count > uev_pkg::MinDigits &&
                             escape_state.lead_zero)
                        escape_state.verdict = uev_pkg::ST_LEAD_ZERO;
                    else begin
                        ready = 1'b1;
                        if (ch == uev_pkg::ChNul) begin
                            escape_state.verdict = uev_pkg::ST_VALID;
                        end else begin
                            escape_state.phase = uev_pkg::PH_START;
                            escape_state.value = '0;
                            escape_state.digit_count = '0;
                            escape_state.lead_zero = 1'b0;
                        end
                    end
                    if (escape_state.verdict != uev_pkg::ST_PENDING)
                        escape_state.phase = uev_pkg::PH_DONE;
                end else if (is_digit) begin
                    grown = 32'(escape_state.value) * Radix + 32'(digit);
                    if (grown > 32'(uev_pkg::MaxCode)) begin
                        escape_state.verdict = uev_pkg::ST_RANGE;
                        escape_state.phase = uev_pkg::PH_DONE;
                    end else begin
                        if (escape_state.phase == uev_pkg::PH_START)
                            escape_state.lead_zero = (digit == 4'd0);
                        escape_state.value = grown[uev_pkg::CpW-1:0];
                        if (escape_state.digit_count != uev_pkg::CountMax)
                            escape_state.digit_count = escape_state.digit_count + 3'd1;
                        escape_state.phase = uev_pkg::PH_DIGITS;
                        shown = escape_state.value;
                    end
                end else begin
                    // also covers NUL or '_' where a first digit is due
                    escape_state.verdict = (ch >= ChLowerA && ch <= ChLowerF) ?
                                           uev_pkg::ST_LOWER : uev_pkg::ST_NON_HEX;
                    escape_state.phase = uev_pkg::PH_DONE;
                end
            end
            default: ;  // verdict held, characters ignored
        endcase

        res.status = escape_state.verdict;
        res.code_point = shown;
        res.point_ready = ready;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus construction
    // ------------------------------------------------------------------------
    char_word_t chars_to_send[$];
    logic       start_flag = 1'b0;   // first flag for the next queued word
    logic       count_live = 1'b1;   // word belongs to an escape that is parsed
    int         live_words = 0;
    int         escapes_queued = 0;

    task automatic queue_word(input logic [7:0] ch);
        chars_to_send.push_back('{ch: ch, first: start_flag});
        start_flag = 1'b0;
        if (count_live)
            live_words++;
    endtask

    task automatic queue_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            queue_word(txt[i]);
    endtask

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        return (nib < 4'd10) ? ChDigit0 + 8'(nib) : ChUpperA + 8'(nib) - 8'd10;
    endfunction

    // random byte that is no hex digit of either case
    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if ((b >= ChDigit0 && b <= ChDigit9) || (b >= ChUpperA && b <= ChUpperF) ||
            (b >= ChLowerA && b <= ChLowerF))
            b = b ^ 8'h80;
        return b;
    endfunction

    task automatic queue_component(input flaw_t flaw);
        logic [31:0] cp;
        int          ndig;
        int          spoil;
        logic [7:0]  c;

        spoil = -1;
        case (flaw)
            FL_SHORT: begin
                ndig = $urandom_range(0, 3);
                cp = $urandom_range(0, (1 << (4 * ndig)) - 1);
            end
            FL_PADDED: begin
                ndig = $urandom_range(5, 9);   // past the count saturation too
                cp = $urandom_range(0, 'hFFFF);
            end
            FL_SURR: begin
                ndig = 4;
                cp = $urandom_range(uev_pkg::SurrLo, uev_pkg::SurrHi);
            end
            FL_OVER: begin
                ndig = 6;
                cp = $urandom_range('h110000, 'hFFFFFF);
            end
            default: begin
                case ($urandom_range(0, 2))
                    0: begin
                        ndig = 4;
                        cp = $urandom_range(0, 'hFFFF);
                    end
                    1: begin
                        ndig = 5;
                        cp = $urandom_range('h10000, 'hFFFFF);
                    end
                    default: begin
                        ndig = 6;
                        cp = $urandom_range('h100000, uev_pkg::MaxCode);
                    end
                endcase
                if (flaw == FL_LOWER || flaw == FL_BADCHAR)
                    spoil = $urandom_range(0, ndig - 1);
            end
        endcase

        for (int i = ndig - 1; i >= 0; i--) begin
            c = hex_digit(4'(cp >> (4 * i)));
            if (i == spoil)
                c = (flaw == FL_LOWER) ? ChLowerA + 8'($urandom_range(0, 5)) : junk_byte();
            queue_word(c);
        end
    endtask

    task automatic queue_escape();
        int roll;
        int parts;
        logic [7:0] lead;

        // now and then no first flag: after a verdict the whole escape is ignored
        start_flag = ($urandom_range(0, 11) != 0);
        count_live = start_flag;
        escapes_queued++;
        roll = $urandom_range(0, 19);
        if (roll == 0) begin
            repeat ($urandom_range(1, 6))
                queue_word(8'($urandom_range(0, 255)));
        end else if (roll == 1) begin
            lead = 8'($urandom_range(0, 255));
            if (lead == uev_pkg::ChPrefix)
                lead = lead ^ 8'h01;
            queue_word(lead);
            queue_component(FL_NONE);
            queue_word(uev_pkg::ChNul);
        end else begin
            queue_word(uev_pkg::ChPrefix);
            parts = $urandom_range(1, 3);
            for (int p = 0; p < parts; p++) begin
                if (p > 0)
                    queue_word(uev_pkg::ChSep);
                queue_component(($urandom_range(0, 4) == 0) ?
                                flaw_t'($urandom_range(FL_SHORT, FL_BADCHAR)) : FL_NONE);
            end
            roll = $urandom_range(0, 9);
            if (roll != 0)
                queue_word(uev_pkg::ChNul);     // otherwise cut off by the next escape
            if (roll == 1) begin
                count_live = 1'b0;          // trailing bytes after the verdict
                repeat ($urandom_range(1, 3))
                    queue_word(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // input driver: presents words at the falling edge
    // ------------------------------------------------------------------------
    logic char_taken = 1'b0;     // handshake seen at the last rising edge
    logic result_taken = 1'b0;
    int   tx_gap_left = 0;
    logic tx_steady = 1'b0;      // stretch with no idle cycles on the input

    always @(negedge aclk) begin : feed_chars
        char_word_t w;
        if (aresetn && (!s_tvalid || char_taken)) begin
            if (char_taken) begin
                if ($urandom_range(0, 39) == 0)
                    tx_steady = !tx_steady;
                tx_gap_left = tx_steady ? 0 : $urandom_range(0, 17);
            end
            if (tx_gap_left > 0) begin
                tx_gap_left--;
                s_tvalid <= 1'b0;
            end else if (chars_to_send.size() != 0) begin
                w = chars_to_send.pop_front();
                s_tdata <= w.ch;
                s_tuser <= w.first;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result sink: random stalls plus one long hold that backs up the input
    // ------------------------------------------------------------------------
    int   rx_stall_left = 0;
    int   rx_words = 0;
    logic rx_steady = 1'b0;
    logic backlog_done = 1'b0;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (result_taken) begin
                rx_words++;
                if (!backlog_done && rx_words >= BacklogAt) begin
                    rx_stall_left = BacklogHold;
                    backlog_done = 1'b1;
                end else begin
                    if ($urandom_range(0, 39) == 0)
                        rx_steady = !rx_steady;
                    rx_stall_left = rx_steady ? 0 : $urandom_range(0, 17);
                end
            end
            if (rx_stall_left > 0) begin
                rx_stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks results, then predicts for the accepted character
    // ------------------------------------------------------------------------
    int                   idle_cycles = 0;
    int                   results_checked = 0;
    int                   points_seen = 0;
    int                   mismatches = 0;
    int                   status_hits[16];
    uev_pkg::esc_result_t want;

    always @(posedge aclk) begin
        char_taken <= aresetn && s_tvalid && s_tready;
        result_taken <= aresetn && m_tvalid && m_tready;

        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;

        // results first: a word leaving now belongs to an earlier character
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            status_hits[m_tdata[3:0]]++;
            if (m_tuser[0] === 1'b1)
                points_seen++;
            if (escape_results_due.size() == 0) begin
                $display("%0t: result word with nothing predicted: status %0d cp %h ready %b",
                         $time, m_tdata[3:0], m_tdata[24:4], m_tuser[0]);
                mismatches++;
            end else begin
                want = escape_results_due.pop_front();
                if (m_tdata[3:0] !== want.status || m_tdata[24:4] !== want.code_point ||
                    m_tuser[0] !== want.point_ready || m_tdata[31:25] !== 7'd0) begin
                    $display("%0t: word %0d expected status %0d cp %h ready %b pad 00",
                             $time, results_checked, want.status, want.code_point,
                             want.point_ready);
                    $display("%0t: word %0d actual   status %0d cp %h ready %b pad %h",
                             $time, results_checked, m_tdata[3:0], m_tdata[24:4],
                             m_tuser[0], m_tdata[31:25]);
                    mismatches++;
                end
            end
        end

        if (aresetn && s_tvalid && s_tready)
            escape_results_due.push_back(step_escape(s_tdata, s_tuser[0]));
    end

    // ------------------------------------------------------------------------
    // sequence: stimulus, reset, completion or watchdog
    // ------------------------------------------------------------------------
    logic timed_out = 1'b0;

    initial begin
        foreach (status_hits[i])
            status_hits[i] = 0;

        // no first flag after reset; surrogate at NUL; then a character ignored
        start_flag = 1'b0;
        queue_text("uD800");
        queue_word(uev_pkg::ChNul);
        queue_word(ChUpperA);
        // NUL where the prefix is due
        start_flag = 1'b1;
        queue_word(uev_pkg::ChNul);
        // empty component right after the prefix
        start_flag = 1'b1;
        queue_text("u_");
        // top and bottom code points, two components, valid
        start_flag = 1'b1;
        queue_text("u10FFFF_0000");
        queue_word(uev_pkg::ChNul);
        // lowercase digit
        start_flag = 1'b1;
        queue_text("ua");

        while (live_words < TargetWords)
            queue_escape();

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        fork
            begin
                wait (chars_to_send.size() == 0 && !s_tvalid);
                wait (escape_results_due.size() == 0);
                repeat (DrainCycles) @(posedge aclk);
            end
            begin
                wait (idle_cycles >= WatchdogLimit);
                timed_out = 1'b1;
            end
        join_any
        disable fork;

        if (timed_out)
            $display("%0t: watchdog: no handshake for %0d cycles, %0d words still due",
                     $time, WatchdogLimit, escape_results_due.size());
        $display("covered %0d escapes, %0d result words checked, %0d code points delivered",
                 escapes_queued, results_checked, points_seen);
        $write("words by status: pending %0d valid %0d no-u %0d non-hex %0d lower %0d ",
               status_hits[uev_pkg::ST_PENDING], status_hits[uev_pkg::ST_VALID],
               status_hits[uev_pkg::ST_NO_U], status_hits[uev_pkg::ST_NON_HEX],
               status_hits[uev_pkg::ST_LOWER]);
        $display("range %0d surrogate %0d short %0d lead-zero %0d",
                 status_hits[uev_pkg::ST_RANGE], status_hits[uev_pkg::ST_SURROGATE],
                 status_hits[uev_pkg::ST_SHORT], status_hits[uev_pkg::ST_LEAD_ZERO]);
        if (!timed_out && mismatches == 0)
            $display("unicode_escape_validator_tb: PASS");
        else
            $display("unicode_escape_validator_tb: FAIL");
        $finish;
    end

endmodule

// File: unicode_escape_validator.f
design/uev_pkg.sv
design/uev_step.sv
design/unicode_escape_validator.sv
tb/sv/unicode_escape_validator_tb.sv
